[rtl/core/dth_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dth_pkg
// Shared types, operation and result codes for the deadline timer heap.
// ----------------------------------------------------------------------------
package dth_pkg;

  localparam int TIME_W = 48;
  localparam int ID_W   = 32;
  localparam int DUR_W  = 32;
  localparam int OP_W   = 3;
  localparam int KIND_W = 3;

  localparam logic [OP_W-1:0] OP_SCHEDULE   = 3'd0;
  localparam logic [OP_W-1:0] OP_CANCEL     = 3'd1;
  localparam logic [OP_W-1:0] OP_RESCHEDULE = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEARED   = 3'd5;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   ident;
    logic              live;
  } entry_t;

  // Heap order: earlier deadline first, lower id on a tie.
  function automatic logic earlier(input entry_t a, input entry_t b);
    logic res;
    if (a.deadline != b.deadline) res = (a.deadline < b.deadline);
    else                          res = (a.ident < b.ident);
    return res;
  endfunction

endpackage

[rtl/core/deadline_timer_heap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_heap
// Millisecond timer queue: a binary min-heap of timers held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with operation, duration_ms and
//   timer_id. Results leave on out_valid/out_ready; out_last marks the final
//   result of each request. A tick gives one fired result per expired live
//   timer (earliest first) and then a tick done result; every other request
//   gives exactly one result, and unused operation codes give none.
//   in_ready is high only while no request is in work, so one request is
//   handled at a time. Timing is set by the heap RAM (one write port and
//   one read port, one read per cycle, registered read): schedule reads
//   and checks the parent at each sift-up level, cancel reads and checks
//   each entry scanned, and a tick pops each expired entry with a sift-down
//   and then emits the fired results one at a time.
//   Reset clears time, the id counter and the heap size; RAM contents need
//   no clearing since only entries below the heap size are read.
//   A stalled receiver holds the result in the output register and the
//   sequencer waits before loading the next one; nothing is dropped.
// ----------------------------------------------------------------------------
module deadline_timer_heap
  import dth_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OP_W-1:0]               in_operation,
  input  logic [DUR_W-1:0]              in_duration_ms,
  input  logic [ID_W-1:0]               in_timer_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [KIND_W-1:0]             out_kind,
  output logic [ID_W-1:0]               out_result_id,
  output logic                          out_found,
  output logic [$clog2(CAPACITY+1)-1:0] out_active_count,
  output logic                          out_last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCANRD = 4'd1;
  localparam logic [3:0] S_SCANCK = 4'd2;
  localparam logic [3:0] S_SCHED  = 4'd3;
  localparam logic [3:0] S_SURD   = 4'd4;
  localparam logic [3:0] S_SUCK   = 4'd5;
  localparam logic [3:0] S_TKRD   = 4'd6;
  localparam logic [3:0] S_TKCK   = 4'd7;
  localparam logic [3:0] S_TKLAST = 4'd8;
  localparam logic [3:0] S_SDRDL  = 4'd9;
  localparam logic [3:0] S_SDRDR  = 4'd10;
  localparam logic [3:0] S_SDCMP  = 4'd11;
  localparam logic [3:0] S_EMRD   = 4'd12;
  localparam logic [3:0] S_EMOUT  = 4'd13;
  localparam logic [3:0] S_RESP   = 4'd14;

  entry_t            heap_mem [CAPACITY];
  logic [ID_W-1:0]   fire_mem [CAPACITY];

  logic [3:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic [ID_W-1:0]   tid_r, tid_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [ID_W-1:0]   nid_r, nid_nxt;
  logic [CNT_W-1:0]  size_r, size_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              found_r, found_nxt;
  entry_t            mov_r, mov_nxt;
  entry_t            left_r, left_nxt;
  logic              rok_r, rok_nxt;
  logic [CNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic [CNT_W-1:0]  ecnt_r, ecnt_nxt;
  logic [KIND_W-1:0] rkind_r, rkind_nxt;
  logic [ID_W-1:0]   rid_r, rid_nxt;

  logic              ov_r, ov_nxt;
  logic [KIND_W-1:0] okind_r, okind_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic              ofound_r, ofound_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic              olast_r, olast_nxt;

  entry_t            hrd_r;
  logic [ID_W-1:0]   frd_r;

  logic [IDX_W-1:0]  rd_addr;
  logic              hwe;
  logic [IDX_W-1:0]  hwa;
  entry_t            hwd;
  logic              fwe;

  logic              out_free;
  logic [CNT_W:0]    lchild, rchild;
  logic [CNT_W-1:0]  parent;
  logic              ltake, rtake;
  entry_t            cur;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign lchild   = {idx_r, 1'b1};
  assign rchild   = lchild + (CNT_W+1)'(1);
  assign parent   = (idx_r - CNT_W'(1)) >> 1;
  assign ltake    = earlier(left_r, mov_r);
  assign cur      = ltake ? left_r : mov_r;
  assign rtake    = rok_r && earlier(hrd_r, cur);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    dur_nxt   = dur_r;
    tid_nxt   = tid_r;
    now_nxt   = now_r;
    nid_nxt   = nid_r;
    size_nxt  = size_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    mov_nxt   = mov_r;
    left_nxt  = left_r;
    rok_nxt   = rok_r;
    fcnt_nxt  = fcnt_r;
    ecnt_nxt  = ecnt_r;
    rkind_nxt = rkind_r;
    rid_nxt   = rid_r;
    ov_nxt    = ov_r && !out_ready;
    okind_nxt = okind_r;
    oid_nxt   = oid_r;
    ofound_nxt = ofound_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    rd_addr   = idx_r[IDX_W-1:0];
    hwe       = 1'b0;
    hwa       = idx_r[IDX_W-1:0];
    hwd       = mov_r;
    fwe       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          dur_nxt   = in_duration_ms;
          tid_nxt   = in_timer_id;
          found_nxt = 1'b0;
          rid_nxt   = '0;
          idx_nxt   = '0;
          priority if (in_operation == OP_SCHEDULE) begin
            state_nxt = S_SCHED;
          end else if (in_operation == OP_CANCEL || in_operation == OP_RESCHEDULE) begin
            state_nxt = S_SCANRD;
          end else if (in_operation == OP_TICK) begin
            now_nxt   = now_r + TIME_W'(1);
            fcnt_nxt  = '0;
            state_nxt = S_TKRD;
          end else if (in_operation == OP_CLEAR) begin
            size_nxt  = '0;
            rkind_nxt = KIND_CLEARED;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCANRD: begin
        if (idx_r < size_r) begin
          state_nxt = S_SCANCK;
        end else if (op_r == OP_CANCEL) begin
          rkind_nxt = KIND_CANCELED;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SCHED;
        end
      end
      S_SCANCK: begin
        if (hrd_r.ident == tid_r) begin
          hwe       = 1'b1;
          hwd       = hrd_r;
          hwd.live  = 1'b0;
          found_nxt = 1'b1;
          if (op_r == OP_CANCEL) begin
            rkind_nxt = KIND_CANCELED;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCHED;
          end
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_SCANRD;
        end
      end
      S_SCHED: begin
        if (size_r >= CAP_CNT) begin
          rkind_nxt = KIND_REJECTED;
          state_nxt = S_RESP;
        end else begin
          mov_nxt.deadline = now_r + TIME_W'(dur_r);
          mov_nxt.ident    = nid_r;
          mov_nxt.live     = 1'b1;
          rkind_nxt = KIND_SCHEDULED;
          rid_nxt   = nid_r;
          nid_nxt   = nid_r + ID_W'(1);
          idx_nxt   = size_r;
          size_nxt  = size_r + CNT_W'(1);
          state_nxt = S_SURD;
        end
      end
      S_SURD: begin
        if (idx_r == '0) begin
          hwe       = 1'b1;
          state_nxt = S_RESP;
        end else begin
          rd_addr   = parent[IDX_W-1:0];
          state_nxt = S_SUCK;
        end
      end
      S_SUCK: begin
        hwe = 1'b1;
        if (earlier(mov_r, hrd_r)) begin
          // move the parent down into the hole and climb
          hwd       = hrd_r;
          idx_nxt   = parent;
          state_nxt = S_SURD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_TKRD: begin
        rd_addr = '0;
        if (size_r != '0) begin
          state_nxt = S_TKCK;
        end else begin
          ecnt_nxt  = '0;
          rkind_nxt = KIND_TICK_DONE;
          state_nxt = (fcnt_r == '0) ? S_RESP : S_EMRD;
        end
      end
      S_TKCK: begin
        if (hrd_r.deadline <= now_r) begin
          if (hrd_r.live) begin
            fwe      = 1'b1;
            fcnt_nxt = fcnt_r + CNT_W'(1);
          end
          size_nxt  = size_r - CNT_W'(1);
          rd_addr   = size_nxt[IDX_W-1:0];
          state_nxt = (size_nxt != '0) ? S_TKLAST : S_TKRD;
        end else begin
          ecnt_nxt  = '0;
          rkind_nxt = KIND_TICK_DONE;
          state_nxt = (fcnt_r == '0) ? S_RESP : S_EMRD;
        end
      end
      S_TKLAST: begin
        mov_nxt   = hrd_r;
        idx_nxt   = '0;
        state_nxt = S_SDRDL;
      end
      S_SDRDL: begin
        if (lchild < {1'b0, size_r}) begin
          rd_addr   = lchild[IDX_W-1:0];
          state_nxt = S_SDRDR;
        end else begin
          hwe       = 1'b1;
          state_nxt = S_TKRD;
        end
      end
      S_SDRDR: begin
        left_nxt  = hrd_r;
        rok_nxt   = (rchild < {1'b0, size_r});
        rd_addr   = rchild[IDX_W-1:0];
        state_nxt = S_SDCMP;
      end
      S_SDCMP: begin
        hwe = 1'b1;
        priority if (rtake) begin
          hwd       = hrd_r;
          idx_nxt   = rchild[CNT_W-1:0];
          state_nxt = S_SDRDL;
        end else if (ltake) begin
          hwd       = left_r;
          idx_nxt   = lchild[CNT_W-1:0];
          state_nxt = S_SDRDL;
        end else begin
          state_nxt = S_TKRD;
        end
      end
      S_EMRD: begin
        state_nxt = S_EMOUT;
      end
      S_EMOUT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = KIND_FIRED;
          oid_nxt    = frd_r;
          ofound_nxt = 1'b0;
          ocnt_nxt   = size_r;
          olast_nxt  = 1'b0;
          ecnt_nxt   = ecnt_r + CNT_W'(1);
          state_nxt  = (ecnt_nxt == fcnt_r) ? S_RESP : S_EMRD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = rkind_r;
          oid_nxt    = rid_r;
          ofound_nxt = found_r;
          ocnt_nxt   = size_r;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      now_r   <= '0;
      nid_r   <= '0;
      size_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r   <= now_nxt;
      nid_r   <= nid_nxt;
      size_r  <= size_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    dur_r    <= dur_nxt;
    tid_r    <= tid_nxt;
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    mov_r    <= mov_nxt;
    left_r   <= left_nxt;
    rok_r    <= rok_nxt;
    fcnt_r   <= fcnt_nxt;
    ecnt_r   <= ecnt_nxt;
    rkind_r  <= rkind_nxt;
    rid_r    <= rid_nxt;
    okind_r  <= okind_nxt;
    oid_r    <= oid_nxt;
    ofound_r <= ofound_nxt;
    ocnt_r   <= ocnt_nxt;
    olast_r  <= olast_nxt;
  end

  // heap RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (hwe) heap_mem[hwa] <= hwd;
    hrd_r <= heap_mem[rd_addr];
  end

  // fired id buffer: filled during the pops, drained afterward
  always_ff @(posedge clk) begin
    if (fwe) fire_mem[fcnt_r[IDX_W-1:0]] <= hrd_r.ident;
    frd_r <= fire_mem[ecnt_r[IDX_W-1:0]];
  end

  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_result_id    = oid_r;
  assign out_found        = ofound_r;
  assign out_active_count = ocnt_r;
  assign out_last         = olast_r;

endmodule
